// ===== rtl/arqrw_pkg.sv =====
// ----------------------------------------------------------------------------
// arqrw_pkg: shared types and constants for the ARQ receive window
// Sequence space, field widths, codes, sequencer states and the ring control
// structs used between the sequencer and the slot ring.
// ----------------------------------------------------------------------------
package arqrw_pkg;

	localparam int SEQ_W    = 31;
	localparam int LEN_W    = 11;
	localparam int HANDLE_W = 16;
	localparam int PLEN_W   = 16;
	localparam int WIN_W    = 6;

	localparam int DEF_WINDOW_DEPTH = 32;
	localparam int DEF_MAX_PAYLOAD  = 1024;

	// last valid sequence number; the space wraps to zero after it
	localparam logic [SEQ_W-1:0] SEQ_LIMIT = 31'd2147463647;
	// size of the sequence space
	localparam logic [31:0]      SEQ_SPAN  = 32'd2147463648;

	// packet kinds (code 3 behaves as other flags)
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_FIN   = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;

	// result kinds
	localparam logic [1:0] RES_ACK     = 2'd0;
	localparam logic [1:0] RES_DELIVER = 2'd1;
	localparam logic [1:0] RES_FINISH  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;
	localparam logic [1:0] REG_START  = 2'd2;

	// arq modes
	localparam logic MODE_GBN = 1'b0;
	localparam logic MODE_SR  = 1'b1;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd8;

	typedef enum logic [1:0] {
		ALU_DIFF,
		ALU_WRAP,
		ALU_INC
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIFF,
		S_WRAP,
		S_PLACE,
		S_RD,
		S_DLV_RING,
		S_DLV_IN,
		S_ADV,
		S_CHK,
		S_ACK,
		S_FIN
	} state_t;

	typedef struct packed {
		logic clear;
		logic store;
		logic adv;
		logic rd;
	} ring_ctrl_t;

	typedef struct packed {
		logic head_held;
		logic slot_held;
	} ring_stat_t;

endpackage

// ===== rtl/arqrw_if.sv =====
// ----------------------------------------------------------------------------
// arqrw_if: valid/ready channels of the ARQ receive window
// Packet descriptor channel and result channel, each with source and sink.
// ----------------------------------------------------------------------------
interface arqrw_in_if;
	logic        valid;
	logic        ready;
	logic [30:0] seq_num;
	logic [1:0]  pkt_kind;
	logic [15:0] pkt_length;
	logic        checksum_ok;
	logic [15:0] buffer_handle;

	modport source (
		output valid, seq_num, pkt_kind, pkt_length, checksum_ok, buffer_handle,
		input  ready
	);
	modport sink (
		input  valid, seq_num, pkt_kind, pkt_length, checksum_ok, buffer_handle,
		output ready
	);
endinterface

interface arqrw_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [30:0] result_seq;
	logic [15:0] out_handle;
	logic [10:0] out_length;
	logic        last;

	modport source (
		output valid, result_kind, result_seq, out_handle, out_length, last,
		input  ready
	);
	modport sink (
		input  valid, result_kind, result_seq, out_handle, out_length, last,
		output ready
	);
endinterface

// ===== rtl/arqrw_alu.sv =====
// ----------------------------------------------------------------------------
// arqrw_alu: shared sequence arithmetic unit
// One 32-bit adder: sequence difference, wrap correction, wrapping increment.
// ----------------------------------------------------------------------------
module arqrw_alu (
	input  arqrw_pkg::alu_op_t op,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	output logic [31:0]        y
);
	import arqrw_pkg::*;

	logic [31:0] opb;
	logic        cin;
	logic [31:0] sum;

	always_comb begin
		case (op)
			ALU_DIFF: begin
				opb = ~b;
				cin = 1'b1;
			end
			ALU_WRAP: begin
				opb = SEQ_SPAN;
				cin = 1'b0;
			end
			ALU_INC: begin
				opb = 32'd0;
				cin = 1'b1;
			end
			default: begin
				opb = 32'd0;
				cin = 1'b0;
			end
		endcase
	end

	assign sum = a + opb + {31'd0, cin};

	// increment past the top of the sequence space wraps to zero
	assign y = (op == ALU_INC && a >= {1'b0, SEQ_LIMIT}) ? 32'd0 : sum;

endmodule

// ===== rtl/arqrw_ring.sv =====
// ----------------------------------------------------------------------------
// arqrw_ring: out-of-order slot ring
// Held bits and head pointer in flops, handle and length in a small memory
// written at base offset and read at the head with registered data.
// ----------------------------------------------------------------------------
module arqrw_ring #(
	parameter int WINDOW_DEPTH = arqrw_pkg::DEF_WINDOW_DEPTH,
	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  arqrw_pkg::ring_ctrl_t         ctrl,
	input  logic [IDX_W-1:0]              off,
	input  logic [arqrw_pkg::HANDLE_W-1:0] wr_handle,
	input  logic [arqrw_pkg::LEN_W-1:0]    wr_length,
	output arqrw_pkg::ring_stat_t         stat,
	output logic [arqrw_pkg::HANDLE_W-1:0] rd_handle,
	output logic [arqrw_pkg::LEN_W-1:0]    rd_length
);
	import arqrw_pkg::*;

	logic [WINDOW_DEPTH-1:0] held_q;
	logic [IDX_W-1:0]        head_q;
	logic [IDX_W-1:0]        head_nxt;
	logic [IDX_W:0]          slot_sum;
	logic [IDX_W:0]          slot_mod;
	logic [IDX_W-1:0]        slot;

	logic [HANDLE_W-1:0] handle_mem [WINDOW_DEPTH];
	logic [LEN_W-1:0]    length_mem [WINDOW_DEPTH];
	logic [HANDLE_W-1:0] rd_handle_q;
	logic [LEN_W-1:0]    rd_length_q;

	// head + offset, modulo depth (offset is below the depth)
	assign slot_sum = {1'b0, head_q} + {1'b0, off};
	assign slot_mod = (slot_sum >= (IDX_W+1)'(WINDOW_DEPTH)) ?
		slot_sum - (IDX_W+1)'(WINDOW_DEPTH) : slot_sum;
	assign slot     = slot_mod[IDX_W-1:0];
	assign head_nxt = (head_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;

	assign stat.head_held = held_q[head_q];
	assign stat.slot_held = held_q[slot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			head_q <= '0;
		end else if (ctrl.clear) begin
			held_q <= '0;
			head_q <= '0;
		end else begin
			if (ctrl.store)
				held_q[slot] <= 1'b1;
			if (ctrl.adv) begin
				held_q[head_q] <= 1'b0;
				head_q         <= head_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.store) begin
			handle_mem[slot] <= wr_handle;
			length_mem[slot] <= wr_length;
		end
		if (ctrl.rd) begin
			rd_handle_q <= handle_mem[head_q];
			rd_length_q <= length_mem[head_q];
		end
	end

	assign rd_handle = rd_handle_q;
	assign rd_length = rd_length_q;

endmodule

// ===== rtl/arq_receive_window_top.sv =====
// ----------------------------------------------------------------------------
// arq_receive_window_top: go-back-N / selective-repeat receive window
// Takes packet descriptors, tracks the expected sequence number, holds
// out-of-order data in a slot ring and issues ACK, deliver and finish beats.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake            | beat
//  ---------+-----+----------------------+-----------------------------------
//  in_ch    | in  | valid/ready          | one packet descriptor
//  out_ch   | out | valid/ready          | one result, last marks the final
//  cfg      | in  | cfg_write, no stall  | one register write by index
//
//  Steps: bare ACK; go-back-N in-order delivery: deliver, advance, ACK;
//  selective-repeat data beat: difference, wrap, place, ACK (difference,
//  ACK when past the sequence space), plus, per slot drained from the ring,
//  read, deliver, advance, check, all through the one shared adder.
//  Reset: arst_n clears mode, window (8), base (0), ring and finish flag; no
//  clearing pass, held bits clear together. A start_seq write restarts.
//  Stalls: in_ch is ready only while idle; every emitting state waits while
//  the output register is full and out_ch.ready is low.
//
module arq_receive_window_top #(
	parameter int WINDOW_DEPTH = arqrw_pkg::DEF_WINDOW_DEPTH,
	parameter int MAX_PAYLOAD  = arqrw_pkg::DEF_MAX_PAYLOAD
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [1:0]                cfg_index,
	input  logic [arqrw_pkg::SEQ_W-1:0] cfg_data,
	arqrw_in_if.sink                  in_ch,
	arqrw_out_if.source               out_ch
);
	import arqrw_pkg::*;

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	state_t state_q, state_nxt;

	// configuration
	logic             mode_q;
	logic [WIN_W-1:0] wl_q;
	logic [WIN_W-1:0] win;
	logic             cfg_start;
	logic [SEQ_W-1:0] start_wrapped;

	// session state
	logic [SEQ_W-1:0] base_q;
	logic             done_q;

	// latched item
	logic [SEQ_W-1:0]    seq_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [LEN_W-1:0]    len_q;
	logic [31:0]         diff_q;

	// output register
	logic                out_valid_q;
	logic [1:0]          okind_q;
	logic [SEQ_W-1:0]    oseq_q;
	logic [HANDLE_W-1:0] ohandle_q;
	logic [LEN_W-1:0]    olen_q;
	logic                olast_q;
	logic                out_free;

	// item decode at accept
	logic in_acc, in_good, in_hit;

	// window test on the offset
	logic in_win, off_zero;

	// sequencer outputs
	alu_op_t             alu_op;
	logic [31:0]         alu_a, alu_b, alu_y;
	ring_ctrl_t          ring_ctrl;
	ring_stat_t          ring_st;
	logic [HANDLE_W-1:0] rd_handle;
	logic [LEN_W-1:0]    rd_length;
	logic                load_diff, base_adv, set_done;
	logic                emit, e_last;
	logic [1:0]          e_kind;
	logic [SEQ_W-1:0]    e_seq;
	logic [HANDLE_W-1:0] e_handle;
	logic [LEN_W-1:0]    e_len;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign in_good = in_ch.checksum_ok && (in_ch.pkt_length <= PLEN_W'(MAX_PAYLOAD));
	assign in_hit  = (in_ch.seq_num == base_q);

	assign cfg_start     = cfg_write && (cfg_index == REG_START);
	assign start_wrapped = (cfg_data > SEQ_LIMIT) ? cfg_data - SEQ_SPAN[SEQ_W-1:0] : cfg_data;

	// window of zero counts as one, above the ring depth saturates
	assign win = (wl_q == '0) ? WIN_W'(1) :
		(wl_q > WIN_W'(WINDOW_DEPTH)) ? WIN_W'(WINDOW_DEPTH) : wl_q;

	assign in_win   = (diff_q[31:WIN_W] == '0) && (diff_q[WIN_W-1:0] < win);
	assign off_zero = (diff_q == 32'd0);

	assign out_free = !out_valid_q || out_ch.ready;

	arqrw_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	arqrw_ring #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ring_ctrl),
		.off       (diff_q[IDX_W-1:0]),
		.wr_handle (handle_q),
		.wr_length (len_q),
		.stat      (ring_st),
		.rd_handle (rd_handle),
		.rd_length (rd_length)
	);

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && !done_q) begin
					if (mode_q == MODE_GBN) begin
						if (in_good && in_hit && in_ch.pkt_kind == KIND_FIN)
							state_nxt = S_FIN;
						else if (in_good && in_hit && in_ch.pkt_kind == KIND_DATA)
							state_nxt = S_DLV_IN;
						else
							state_nxt = S_ACK;
					end else if (in_good) begin
						if (in_ch.pkt_kind == KIND_FIN)
							state_nxt = in_hit ? S_FIN : S_IDLE;
						else if (in_ch.pkt_kind == KIND_DATA)
							state_nxt = S_DIFF;
						else
							state_nxt = S_ACK;
					end
				end
			end
			// sequence numbers past the limit are never in the window
			S_DIFF:     state_nxt = (seq_q > SEQ_LIMIT) ? S_ACK : S_WRAP;
			S_WRAP:     state_nxt = S_PLACE;
			S_PLACE:    state_nxt = (in_win && !ring_st.slot_held && off_zero) ? S_RD : S_ACK;
			S_RD:       state_nxt = S_DLV_RING;
			S_DLV_RING: state_nxt = out_free ? S_ADV : S_DLV_RING;
			S_DLV_IN:   state_nxt = out_free ? S_ADV : S_DLV_IN;
			S_ADV:      state_nxt = (mode_q == MODE_SR) ? S_CHK : S_ACK;
			S_CHK:      state_nxt = ring_st.head_held ? S_RD : S_ACK;
			S_ACK:      state_nxt = out_free ? S_IDLE : S_ACK;
			S_FIN:      state_nxt = out_free ? S_IDLE : S_FIN;
			default:    state_nxt = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer outputs
	// ------------------------------------------------------------------
	always_comb begin
		in_ch.ready     = (state_q == S_IDLE);
		alu_op          = ALU_DIFF;
		alu_a           = {1'b0, seq_q};
		alu_b           = {1'b0, base_q};
		ring_ctrl.clear = cfg_start;
		ring_ctrl.store = 1'b0;
		ring_ctrl.adv   = 1'b0;
		ring_ctrl.rd    = 1'b0;
		load_diff       = 1'b0;
		base_adv        = 1'b0;
		set_done        = 1'b0;
		emit            = 1'b0;
		e_kind          = RES_ACK;
		e_seq           = base_q;
		e_handle        = '0;
		e_len           = '0;
		e_last          = 1'b0;
		case (state_q)
			S_DIFF: begin
				load_diff = 1'b1;
			end
			S_WRAP: begin
				// negative difference: add the sequence space back
				alu_op    = ALU_WRAP;
				alu_a     = diff_q;
				load_diff = diff_q[31];
			end
			S_PLACE: begin
				ring_ctrl.store = in_win && !ring_st.slot_held;
			end
			S_RD: begin
				ring_ctrl.rd = 1'b1;
			end
			S_DLV_RING: begin
				emit     = 1'b1;
				e_kind   = RES_DELIVER;
				e_seq    = base_q;
				e_handle = rd_handle;
				e_len    = rd_length;
			end
			S_DLV_IN: begin
				emit     = 1'b1;
				e_kind   = RES_DELIVER;
				e_seq    = seq_q;
				e_handle = handle_q;
				e_len    = len_q;
			end
			S_ADV: begin
				alu_op        = ALU_INC;
				alu_a         = {1'b0, base_q};
				ring_ctrl.adv = 1'b1;
				base_adv      = 1'b1;
			end
			S_ACK: begin
				emit   = 1'b1;
				e_kind = RES_ACK;
				e_seq  = (mode_q == MODE_SR) ? seq_q : base_q;
				e_last = 1'b1;
			end
			S_FIN: begin
				emit     = 1'b1;
				e_kind   = RES_FINISH;
				e_seq    = seq_q;
				e_last   = 1'b1;
				set_done = out_free;
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GBN;
			wl_q   <= WINDOW_RESET;
			base_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_write && cfg_index == REG_MODE)
				mode_q <= cfg_data[0];
			if (cfg_write && cfg_index == REG_WINDOW)
				wl_q <= cfg_data[WIN_W-1:0];
			if (cfg_start) begin
				base_q <= start_wrapped;
				done_q <= 1'b0;
			end else begin
				if (base_adv)
					base_q <= alu_y[SEQ_W-1:0];
				if (set_done)
					done_q <= 1'b1;
			end
		end
	end

	// item payload and offset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			seq_q    <= in_ch.seq_num;
			handle_q <= in_ch.buffer_handle;
			len_q    <= in_ch.pkt_length[LEN_W-1:0];
		end
		if (load_diff)
			diff_q <= alu_y;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit && out_free)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			okind_q   <= e_kind;
			oseq_q    <= e_seq;
			ohandle_q <= e_handle;
			olen_q    <= e_len;
			olast_q   <= e_last;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.result_kind = okind_q;
	assign out_ch.result_seq  = oseq_q;
	assign out_ch.out_handle  = ohandle_q;
	assign out_ch.out_length  = olen_q;
	assign out_ch.last        = olast_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_base_in_space: assert property (@(posedge clk) disable iff (!arst_n)
		base_q <= SEQ_LIMIT)
		else $error("base sequence left the sequence space");

	a_offset_in_space: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE) |-> (!diff_q[31] && diff_q[30:0] <= SEQ_LIMIT))
		else $error("window offset not reduced into the sequence space");

	a_fin_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free && !cfg_start) |=> done_q)
		else $error("finish beat did not close the session");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && done_q) |=> (state_q == S_IDLE && !emit))
		else $error("item after finish started work");

endmodule
